>>> sv/xxh_pkg.sv
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P64_1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P64_2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P64_3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P64_4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P64_5 = 64'h27D4EB2F165667C5;

  localparam logic [3:0] FULL_BYTES = 4'd8;
  localparam logic [3:0] HALF_BYTES = 4'd4;
  localparam logic [1:0] STRIPE_SLOTS = 2'd3;
  localparam logic [1:0] LAST_LANE = 2'd3;

  // multiplier operand a
  localparam logic [2:0] A_BUF  = 3'd0;
  localparam logic [2:0] A_W    = 3'd1;
  localparam logic [2:0] A_LANE = 3'd2;
  localparam logic [2:0] A_W32  = 3'd3;
  localparam logic [2:0] A_BYTE = 3'd4;
  localparam logic [2:0] A_T    = 3'd5;
  localparam logic [2:0] A_H    = 3'd6;

  // multiplier operand b
  localparam logic [1:0] B_P1 = 2'd0;
  localparam logic [1:0] B_P2 = 2'd1;
  localparam logic [1:0] B_P3 = 2'd2;
  localparam logic [1:0] B_P5 = 2'd3;

  // accumulator operations
  localparam logic [3:0] H_NOP   = 4'd0;
  localparam logic [3:0] H_CLR   = 4'd1;
  localparam logic [3:0] H_SEED  = 4'd2;
  localparam logic [3:0] H_CONV  = 4'd3;
  localparam logic [3:0] H_LEN   = 4'd4;
  localparam logic [3:0] H_XORP  = 4'd5;
  localparam logic [3:0] H_P     = 4'd6;
  localparam logic [3:0] H_PP3   = 4'd7;
  localparam logic [3:0] H_PP4   = 4'd8;
  localparam logic [3:0] H_SHX33 = 4'd9;
  localparam logic [3:0] H_PSX29 = 4'd10;

  // temporary register operations
  localparam logic [2:0] T_NOP   = 3'd0;
  localparam logic [2:0] T_LANEP = 3'd1;
  localparam logic [2:0] T_P31   = 3'd2;
  localparam logic [2:0] T_H27   = 3'd3;
  localparam logic [2:0] T_H23   = 3'd4;
  localparam logic [2:0] T_H11   = 3'd5;

  typedef struct packed {
    logic       cap;
    logic       tot8;
    logic       len_ld;
    logic       buf_wr;
    logic       lane_seed;
    logic       lane_wr;
    logic       stripe_done;
    logic       bc_clr;
    logic       msg_done;
    logic       out_ld;
    logic       mul_start;
    logic [2:0] mul_a;
    logic [1:0] mul_b;
    logic [1:0] idx;
    logic [2:0] bidx;
    logic [3:0] h_op;
    logic [2:0] t_op;
  } ctl_t;

  typedef struct packed {
    logic       last;
    logic [3:0] bc;
    logic [1:0] slot;
    logic       seen;
    logic       mul_done;
    logic       out_busy;
  } sts_t;

  function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
    rol64 = (v << n) | (v >> (64 - n));
  endfunction

endpackage
`default_nettype wire

>>> sv/xxh_in_if.sv
`default_nettype none
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface
`default_nettype wire

>>> sv/xxh_out_if.sv
`default_nettype none
interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface
`default_nettype wire

>>> sv/xxh_mul.sv
`default_nettype none
module xxh_mul
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic             busy,
  output logic [63:0]      p
);

  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] acc;
  logic [1:0]  phase;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] pp;

  // low 64 bits only: lo*lo, then both cross terms shifted up
  always_comb begin
    case (phase)
      2'd0: begin
        op_x = ra[31:0];
        op_y = rb[31:0];
      end
      2'd1: begin
        op_x = ra[63:32];
        op_y = rb[31:0];
      end
      default: begin
        op_x = ra[31:0];
        op_y = rb[63:32];
      end
    endcase
    pp = {32'd0, op_x} * {32'd0, op_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
    end else if (busy) begin
      if (phase == 2'd0) begin
        acc <= pp;
      end else begin
        acc <= acc + {pp[31:0], 32'd0};
      end
    end
  end

  assign p = acc;

endmodule
`default_nettype wire

>>> sv/xxh_datapath.sv
`default_nettype none
module xxh_datapath
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire logic [63:0] seed,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value
);

  logic [63:0] w_r;
  logic [3:0]  bc_r;
  logic        last_r;
  logic [63:0] wbuf [3];
  logic [63:0] lane [4];
  logic [1:0]  slot;
  logic [31:0] total;
  logic        seen;
  logic [31:0] len_r;
  logic [63:0] h;
  logic [63:0] t;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] p;
  logic        mul_done;
  logic        mul_busy;
  logic [63:0] conv_term;
  logic [63:0] h_next;
  logic [63:0] t_next;

  xxh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .busy  (mul_busy),
    .p     (p)
  );

  always_comb begin
    case (ctl.mul_a)
      A_BUF:   mul_a = wbuf[ctl.idx];
      A_W:     mul_a = w_r;
      A_LANE:  mul_a = lane[ctl.idx];
      A_W32:   mul_a = {32'd0, w_r[31:0]};
      A_BYTE:  mul_a = {56'd0, w_r[8*ctl.bidx +: 8]};
      A_T:     mul_a = t;
      default: mul_a = h;
    endcase
    case (ctl.mul_b)
      B_P1:    mul_b = P64_1;
      B_P2:    mul_b = P64_2;
      B_P3:    mul_b = P64_3;
      default: mul_b = P64_5;
    endcase
  end

  always_comb begin
    case (ctl.idx)
      2'd0:    conv_term = rol64(lane[0], 1);
      2'd1:    conv_term = rol64(lane[1], 7);
      2'd2:    conv_term = rol64(lane[2], 12);
      default: conv_term = rol64(lane[3], 18);
    endcase
    case (ctl.h_op)
      H_CLR:   h_next = 64'd0;
      H_SEED:  h_next = seed + P64_5;
      H_CONV:  h_next = h + conv_term;
      H_LEN:   h_next = h + {32'd0, len_r};
      H_XORP:  h_next = h ^ p;
      H_P:     h_next = p;
      H_PP3:   h_next = p + P64_3;
      H_PP4:   h_next = p + P64_4;
      H_SHX33: h_next = h ^ (h >> 33);
      H_PSX29: h_next = p ^ (p >> 29);
      default: h_next = h;
    endcase
    case (ctl.t_op)
      T_LANEP: t_next = rol64(lane[ctl.idx] + p, 31);
      T_P31:   t_next = rol64(p, 31);
      T_H27:   t_next = rol64(h, 27);
      T_H23:   t_next = rol64(h, 23);
      T_H11:   t_next = rol64(h, 11);
      default: t_next = t;
    endcase
  end

  always_ff @(posedge clk) begin
    h <= h_next;
    t <= t_next;
    if (ctl.cap) begin
      w_r    <= data_word;
      last_r <= last_word;
      if (!last_word) begin
        bc_r <= FULL_BYTES;
      end else if (byte_count > FULL_BYTES) begin
        bc_r <= FULL_BYTES;
      end else begin
        bc_r <= byte_count;
      end
    end else if (ctl.bc_clr) begin
      bc_r <= 4'd0;
    end
    if (ctl.len_ld) begin
      len_r <= total + {28'd0, bc_r};
    end
    if (ctl.buf_wr) begin
      wbuf[slot] <= w_r;
    end
    if (ctl.lane_seed) begin
      lane[0] <= seed + P64_1 + P64_2;
      lane[1] <= seed + P64_2;
      lane[2] <= seed;
      lane[3] <= seed - P64_1;
    end else if (ctl.lane_wr) begin
      lane[ctl.idx] <= p;
    end
    if (ctl.out_ld) begin
      hash_value <= p ^ (p >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      total     <= 32'd0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.tot8) begin
        total <= total + 32'd8;
      end
      if (ctl.buf_wr) begin
        slot <= slot + 2'd1;
      end
      if (ctl.stripe_done) begin
        slot <= 2'd0;
        seen <= 1'b1;
      end
      if (ctl.msg_done) begin
        slot  <= 2'd0;
        total <= 32'd0;
        seen  <= 1'b0;
      end
      if (ctl.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.last     = last_r;
  assign sts.bc       = bc_r;
  assign sts.slot     = slot;
  assign sts.seen     = seen;
  assign sts.mul_done = mul_done;
  assign sts.out_busy = out_valid & ~out_ready;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");
  a_buf_room: assert property (@(posedge clk) disable iff (rst)
    ctl.buf_wr |-> slot != STRIPE_SLOTS)
    else $error("word buffer overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.out_ld |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

>>> sv/xxh_ctrl.sv
`default_nettype none
module xxh_ctrl
  import xxh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_DECODE  = 6'd1;
  localparam logic [5:0] S_ST_INIT = 6'd2;
  localparam logic [5:0] S_LR_M1   = 6'd3;
  localparam logic [5:0] S_LR_T    = 6'd4;
  localparam logic [5:0] S_LR_M2   = 6'd5;
  localparam logic [5:0] S_LR_W    = 6'd6;
  localparam logic [5:0] S_HSTART  = 6'd7;
  localparam logic [5:0] S_CONV    = 6'd8;
  localparam logic [5:0] S_RD_M1   = 6'd9;
  localparam logic [5:0] S_RD_T    = 6'd10;
  localparam logic [5:0] S_RD_M2   = 6'd11;
  localparam logic [5:0] S_RD_X    = 6'd12;
  localparam logic [5:0] S_RD_R    = 6'd13;
  localparam logic [5:0] S_RD_M3   = 6'd14;
  localparam logic [5:0] S_RD_A    = 6'd15;
  localparam logic [5:0] S_HLEN    = 6'd16;
  localparam logic [5:0] S_TW_CHK  = 6'd17;
  localparam logic [5:0] S_Q_CHK   = 6'd18;
  localparam logic [5:0] S_Q_X     = 6'd19;
  localparam logic [5:0] S_Q_R     = 6'd20;
  localparam logic [5:0] S_Q_M2    = 6'd21;
  localparam logic [5:0] S_Q_A     = 6'd22;
  localparam logic [5:0] S_B_CHK   = 6'd23;
  localparam logic [5:0] S_B_X     = 6'd24;
  localparam logic [5:0] S_B_R     = 6'd25;
  localparam logic [5:0] S_B_M2    = 6'd26;
  localparam logic [5:0] S_B_A     = 6'd27;
  localparam logic [5:0] S_F1      = 6'd28;
  localparam logic [5:0] S_F2      = 6'd29;
  localparam logic [5:0] S_F3      = 6'd30;
  localparam logic [5:0] S_F4      = 6'd31;
  localparam logic [5:0] S_F5      = 6'd32;
  localparam logic [5:0] S_MULW    = 6'd33;

  logic [5:0] state;
  logic [5:0] state_next;
  logic [5:0] ret;
  logic [5:0] ret_next;
  logic [1:0] k;
  logic [1:0] k_next;
  logic [3:0] bi;
  logic [3:0] bi_next;
  logic       merge;
  logic       merge_next;
  logic       tw_cur;
  logic       tw_cur_next;
  logic       eat_last;
  logic       eat_last_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    k_next        = k;
    bi_next       = bi;
    merge_next    = merge;
    tw_cur_next   = tw_cur;
    eat_last_next = eat_last;
    ctl           = '0;
    ctl.idx       = k;
    ctl.bidx      = bi[2:0];
    ctl.h_op      = H_NOP;
    ctl.t_op      = T_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap    = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.last) begin
          ctl.tot8 = 1'b1;
          if (sts.slot == STRIPE_SLOTS) begin
            eat_last_next = 1'b0;
            state_next    = S_ST_INIT;
          end else begin
            ctl.buf_wr = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          ctl.len_ld = 1'b1;
          if (sts.bc == FULL_BYTES && sts.slot == STRIPE_SLOTS) begin
            eat_last_next = 1'b1;
            state_next    = S_ST_INIT;
          end else begin
            state_next = S_HSTART;
          end
        end
      end
      S_ST_INIT: begin
        ctl.lane_seed = !sts.seen;
        k_next        = 2'd0;
        state_next    = S_LR_M1;
      end
      S_LR_M1: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = (k == LAST_LANE) ? A_W : A_BUF;
        ctl.mul_b     = B_P2;
        ret_next      = S_LR_T;
        state_next    = S_MULW;
      end
      S_LR_T: begin
        ctl.t_op   = T_LANEP;
        state_next = S_LR_M2;
      end
      S_LR_M2: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_T;
        ctl.mul_b     = B_P1;
        ret_next      = S_LR_W;
        state_next    = S_MULW;
      end
      S_LR_W: begin
        ctl.lane_wr = 1'b1;
        if (k == LAST_LANE) begin
          ctl.stripe_done = 1'b1;
          if (eat_last) begin
            // the last word went into the stripe, nothing left of it
            ctl.bc_clr = 1'b1;
            state_next = S_HSTART;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          k_next     = k + 2'd1;
          state_next = S_LR_M1;
        end
      end
      S_HSTART: begin
        if (sts.seen) begin
          ctl.h_op   = H_CLR;
          k_next     = 2'd0;
          state_next = S_CONV;
        end else begin
          ctl.h_op   = H_SEED;
          state_next = S_HLEN;
        end
      end
      S_CONV: begin
        ctl.h_op = H_CONV;
        if (k == LAST_LANE) begin
          k_next     = 2'd0;
          merge_next = 1'b1;
          state_next = S_RD_M1;
        end else begin
          k_next = k + 2'd1;
        end
      end
      S_RD_M1: begin
        ctl.mul_start = 1'b1;
        if (merge) begin
          ctl.mul_a = A_LANE;
        end else begin
          ctl.mul_a = tw_cur ? A_W : A_BUF;
        end
        ctl.mul_b  = B_P2;
        ret_next   = S_RD_T;
        state_next = S_MULW;
      end
      S_RD_T: begin
        ctl.t_op   = T_P31;
        state_next = S_RD_M2;
      end
      S_RD_M2: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_T;
        ctl.mul_b     = B_P1;
        ret_next      = S_RD_X;
        state_next    = S_MULW;
      end
      S_RD_X: begin
        ctl.h_op   = H_XORP;
        state_next = S_RD_R;
      end
      S_RD_R: begin
        if (merge) begin
          ctl.mul_start = 1'b1;
          ctl.mul_a     = A_H;
          ctl.mul_b     = B_P1;
          ret_next      = S_RD_A;
          state_next    = S_MULW;
        end else begin
          ctl.t_op   = T_H27;
          state_next = S_RD_M3;
        end
      end
      S_RD_M3: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_T;
        ctl.mul_b     = B_P1;
        ret_next      = S_RD_A;
        state_next    = S_MULW;
      end
      S_RD_A: begin
        ctl.h_op = H_PP4;
        if (merge) begin
          if (k == LAST_LANE) begin
            state_next = S_HLEN;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_RD_M1;
          end
        end else if (tw_cur) begin
          state_next = S_F1;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_TW_CHK;
        end
      end
      S_HLEN: begin
        ctl.h_op    = H_LEN;
        k_next      = 2'd0;
        merge_next  = 1'b0;
        tw_cur_next = 1'b0;
        state_next  = S_TW_CHK;
      end
      S_TW_CHK: begin
        if (k < sts.slot) begin
          tw_cur_next = 1'b0;
          state_next  = S_RD_M1;
        end else if (sts.bc == FULL_BYTES) begin
          tw_cur_next = 1'b1;
          state_next  = S_RD_M1;
        end else begin
          state_next = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (sts.bc >= HALF_BYTES) begin
          ctl.mul_start = 1'b1;
          ctl.mul_a     = A_W32;
          ctl.mul_b     = B_P1;
          ret_next      = S_Q_X;
          state_next    = S_MULW;
        end else begin
          bi_next    = 4'd0;
          state_next = S_B_CHK;
        end
      end
      S_Q_X: begin
        ctl.h_op   = H_XORP;
        state_next = S_Q_R;
      end
      S_Q_R: begin
        ctl.t_op   = T_H23;
        state_next = S_Q_M2;
      end
      S_Q_M2: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_T;
        ctl.mul_b     = B_P2;
        ret_next      = S_Q_A;
        state_next    = S_MULW;
      end
      S_Q_A: begin
        ctl.h_op   = H_PP3;
        bi_next    = HALF_BYTES;
        state_next = S_B_CHK;
      end
      S_B_CHK: begin
        if (bi < sts.bc) begin
          ctl.mul_start = 1'b1;
          ctl.mul_a     = A_BYTE;
          ctl.mul_b     = B_P5;
          ret_next      = S_B_X;
          state_next    = S_MULW;
        end else begin
          state_next = S_F1;
        end
      end
      S_B_X: begin
        ctl.h_op   = H_XORP;
        state_next = S_B_R;
      end
      S_B_R: begin
        ctl.t_op   = T_H11;
        state_next = S_B_M2;
      end
      S_B_M2: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_T;
        ctl.mul_b     = B_P1;
        ret_next      = S_B_A;
        state_next    = S_MULW;
      end
      S_B_A: begin
        ctl.h_op   = H_P;
        bi_next    = bi + 4'd1;
        state_next = S_B_CHK;
      end
      S_F1: begin
        ctl.h_op   = H_SHX33;
        state_next = S_F2;
      end
      S_F2: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_H;
        ctl.mul_b     = B_P2;
        ret_next      = S_F3;
        state_next    = S_MULW;
      end
      S_F3: begin
        ctl.h_op   = H_PSX29;
        state_next = S_F4;
      end
      S_F4: begin
        ctl.mul_start = 1'b1;
        ctl.mul_a     = A_H;
        ctl.mul_b     = B_P3;
        ret_next      = S_F5;
        state_next    = S_MULW;
      end
      S_F5: begin
        // hold until the previous hash has been taken
        if (!sts.out_busy) begin
          ctl.out_ld   = 1'b1;
          ctl.msg_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MULW: begin
        if (sts.mul_done) begin
          state_next = ret;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      k        <= 2'd0;
      bi       <= 4'd0;
      merge    <= 1'b0;
      tw_cur   <= 1'b0;
      eat_last <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      k        <= k_next;
      bi       <= bi_next;
      merge    <= merge_next;
      tw_cur   <= tw_cur_next;
      eat_last <= eat_last_next;
    end
  end

`ifndef SYNTHESIS
  a_mul_return: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULW && sts.mul_done) |=> state == $past(ret))
    else $error("sequencer did not resume after multiply");
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.mul_start |=> state == S_MULW)
    else $error("multiply issued without waiting");
  a_cap_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.cap |=> state == S_DECODE)
    else $error("input captured outside idle");
`endif

endmodule
`default_nettype wire

>>> sv/xxhash64_stream.sv
`default_nettype none
// 64-bit xxHash of a message streamed as little-endian 64-bit words; the last word
// carries 0 to 8 bytes (a larger count is taken as 8) and its result comes out on the
// output channel. The seed register (address 0) must be written before a message
// starts. Words are taken one at a time, each once the last is processed. A word that
// only fills the stripe buffer is stored; the word that completes a 32-byte stripe runs
// the four lane rounds sharing one multiplier that builds each 64-bit product from three
// 32x32 partial products. The work for the last word depends on stripes seen,
// buffered words and tail bytes. The next word is taken while a hash waits.
module xxhash64_stream
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  xxh_in_if.sink           in_ch,
  xxh_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] seed;
  ctl_t        ctl;
  sts_t        sts;
  logic        in_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
      seed <= pwdata;
    end
  end

  assign prdata = (paddr[3] == 1'b0) ? seed : 64'd0;

  xxh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  assign in_ch.ready = in_ready;

  xxh_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .seed       (seed),
    .data_word  (in_ch.data_word),
    .byte_count (in_ch.byte_count),
    .last_word  (in_ch.last_word),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .hash_value (out_ch.hash_value)
  );

endmodule
`default_nettype wire

>>> sim/xxhash64_stream_tb.sv
`default_nettype none
module xxhash64_stream_tb;
  import xxh_pkg::*;

  localparam logic [3:0] SEED_ADDR = 4'd0;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  xxh_in_if  in_ch();
  xxh_out_if out_ch();

  xxhash64_stream i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  bc;
    logic        last;
    logic        known;
    logic [63:0] hv;
  } word_row_t;

  // hash model state
  logic [63:0] seed_reg;
  logic [63:0] lanes [4];
  logic [63:0] held [3];
  int unsigned held_cnt;
  logic [31:0] msg_len;
  logic        striped;

  logic [63:0] hash_q [$];
  int          errors;
  int          quiet_cycles;
  bit          busy_out;
  bit          no_idle;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] lane_round(input logic [63:0] acc, input logic [63:0] w);
    return rotl(acc + w * P64_2, 31) * P64_1;
  endfunction

  function automatic logic [63:0] tail_mix(input logic [63:0] h, input logic [63:0] w);
    return rotl(h ^ lane_round(64'd0, w), 27) * P64_1 + P64_4;
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] h);
    logic [63:0] x;
    x = h ^ (h >> 33);
    x = x * P64_2;
    x = x ^ (x >> 29);
    x = x * P64_3;
    return x ^ (x >> 32);
  endfunction

  task automatic consume_stripe(input logic [63:0] w3);
    if (!striped) begin
      lanes[0] = seed_reg + P64_1 + P64_2;
      lanes[1] = seed_reg + P64_2;
      lanes[2] = seed_reg;
      lanes[3] = seed_reg - P64_1;
    end
    lanes[0] = lane_round(lanes[0], held[0]);
    lanes[1] = lane_round(lanes[1], held[1]);
    lanes[2] = lane_round(lanes[2], held[2]);
    lanes[3] = lane_round(lanes[3], w3);
    striped = 1'b1;
    held_cnt = 0;
  endtask

  // returns 1 with the hash when the word closes a message
  task automatic hash_word(input logic [63:0] w, input logic [3:0] bc_in, input logic last,
                           output bit got, output logic [63:0] hv);
    logic [63:0] h;
    logic [31:0] len;
    int unsigned bc;
    int unsigned i;
    got = 0;
    hv = '0;
    if (!last) begin
      msg_len += 32'd8;
      if (held_cnt >= 3) consume_stripe(w);
      else begin
        held[held_cnt] = w;
        held_cnt++;
      end
      return;
    end
    bc = (bc_in > 8) ? 8 : bc_in;
    len = msg_len + bc;
    if (bc == 8 && held_cnt >= 3) begin
      consume_stripe(w);
      bc = 0;
    end
    if (striped) begin
      h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
      for (i = 0; i < 4; i++) h = (h ^ lane_round(64'd0, lanes[i])) * P64_1 + P64_4;
    end else begin
      h = seed_reg + P64_5;
    end
    h += {32'd0, len};
    for (i = 0; i < held_cnt; i++) h = tail_mix(h, held[i]);
    if (bc == 8) h = tail_mix(h, w);
    else begin
      i = 0;
      if (bc >= 4) begin
        h ^= {32'd0, w[31:0]} * P64_1;
        h = rotl(h, 23) * P64_2 + P64_3;
        i = 4;
      end
      for (; i < bc; i++) h = rotl(h ^ ({56'd0, w[8*i +: 8]} * P64_5), 11) * P64_1;
    end
    hv = avalanche(h);
    got = 1;
    held_cnt = 0;
    msg_len = '0;
    striped = 1'b0;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        hold = gap_len();
      end else out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(negedge clk) begin
    busy_out = 0;
    if (!rst && out_ch.valid && out_ch.ready) begin
      busy_out = 1;
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected hash %h", $time, out_ch.hash_value);
        errors++;
      end else begin
        if (out_ch.hash_value !== hash_q[0]) begin
          $display("%0t: hash_value expected %h actual %h", $time, hash_q[0],
                   out_ch.hash_value);
          errors++;
        end
        void'(hash_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(negedge clk) begin
    if (rst || busy_out || (in_ch.valid && in_ch.ready) || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_seed(input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= SEED_ADDR;
    pwdata <= v;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seed_reg = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== v) begin
      $display("%0t: seed readback expected %h actual %h", $time, v, prdata);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(input logic [63:0] w, input logic [3:0] bc, input logic last,
                           input bit known, input logic [63:0] known_hv);
    bit got;
    logic [63:0] hv;
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= w;
    in_ch.byte_count <= bc;
    in_ch.last_word <= last;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    hash_word(w, bc, last, got, hv);
    if (got) hash_q.push_back(known ? known_hv : hv);
  endtask

  task automatic settle();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_message(output int sent);
    int nwords;
    int r;
    logic [3:0] bc;
    r = $urandom_range(0, 99);
    if (r < 70) nwords = $urandom_range(0, 7);
    else if (r < 95) nwords = $urandom_range(8, 24);
    else nwords = $urandom_range(25, 60);
    for (int k = 0; k < nwords; k++)
      send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0, 0, '0);
    bc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    send_word({$urandom, $urandom}, bc, 1'b1, 0, '0);
    sent = nwords + 1;
  endtask

  word_row_t directed [19];
  int items;
  int sent;
  logic [63:0] phase_seed;

  initial begin
    errors = 0;
    quiet_cycles = 0;
    no_idle = 0;
    seed_reg = '0;
    held_cnt = 0;
    msg_len = '0;
    striped = 1'b0;
    directed = '{
      '{64'd0, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},   // empty message
      '{64'h61, 4'd1, 1'b1, 1'b0, '0},
      '{'1, 4'd4, 1'b1, 1'b0, '0},
      '{'1, 4'd7, 1'b1, 1'b0, '0},
      '{64'h0123456789ABCDEF, 4'd8, 1'b1, 1'b0, '0},
      '{'1, 4'd15, 1'b1, 1'b0, '0},                        // count saturates to 8
      '{64'h1111111111111111, 4'd5, 1'b0, 1'b0, '0},       // count ignored mid-message
      '{64'h2222222222222222, 4'd0, 1'b0, 1'b0, '0},
      '{'1, 4'd15, 1'b0, 1'b0, '0},
      '{64'h4444444444444444, 4'd8, 1'b1, 1'b0, '0},       // stripe closes on last word
      '{64'd0, 4'd8, 1'b0, 1'b0, '0},
      '{'1, 4'd8, 1'b0, 1'b0, '0},
      '{64'h5555555555555555, 4'd8, 1'b0, 1'b0, '0},
      '{64'hAAAAAAAAAAAAAAAA, 4'd8, 1'b0, 1'b0, '0},
      '{64'hFEDCBA9876543210, 4'd5, 1'b1, 1'b0, '0},
      '{64'd0, 4'd8, 1'b0, 1'b0, '0},
      '{'1, 4'd0, 1'b1, 1'b0, '0},                         // last word adds no bytes
      '{'1, 4'd8, 1'b0, 1'b0, '0},
      '{64'hAAAAAAAAAAAAAAAA, 4'd3, 1'b1, 1'b0, '0}
    };
    @(negedge rst);
    write_seed(64'd0);
    foreach (directed[k])
      send_word(directed[k].data, directed[k].bc, directed[k].last, directed[k].known,
                directed[k].hv);
    settle();
    items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: phase_seed = '1;
        1: phase_seed = 64'd1;
        default: phase_seed = {$urandom, $urandom};
      endcase
      write_seed(phase_seed);
      no_idle = (ph == 3);
      while (items < (ph + 1) * 200) begin
        send_message(sent);
        items = items + sent;
      end
      settle();
    end
    no_idle = 0;
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
